FILE: hdl/dam_pkg.sv
// ----------------------------------------------------------------------------
// dam_pkg
// Types and constants shared by the decimal accumulator machine files.
// ----------------------------------------------------------------------------
package dam_pkg;

  localparam int WORD_W  = 15;
  localparam int PC_W    = 7;
  localparam int MAG_W   = 14;   // magnitude of a word, |w| <= 9999
  localparam int DIV_BITS = 14;  // quotient bits of the divider
  localparam int DCNT_W  = 4;

  localparam logic signed [WORD_W-1:0] WORD_MAX = 15'sd9999;
  localparam logic signed [WORD_W-1:0] WORD_MIN = -15'sd9999;
  localparam logic signed [15:0]       SUM_MAX  = 16'sd9999;
  localparam logic signed [15:0]       SUM_MIN  = -16'sd9999;
  localparam logic signed [29:0]       PROD_MAX = 30'sd9999;
  localparam logic signed [29:0]       PROD_MIN = -30'sd9999;

  // floor(m / 100) == (m * RECIP_100) >> RECIP_SHIFT for 0 <= m <= 9999
  localparam logic [26:0] RECIP_100   = 27'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_READ    = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_EXEC    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_HALT    = 3'd1,
    ST_BADADDR = 3'd2,
    ST_OVF     = 3'd3,
    ST_DIV0    = 3'd4,
    ST_BADOP   = 3'd5,
    ST_PCRANGE = 3'd6
  } status_t;

  localparam logic [6:0] OP_READ   = 7'd10;
  localparam logic [6:0] OP_WRITE  = 7'd11;
  localparam logic [6:0] OP_LOAD   = 7'd20;
  localparam logic [6:0] OP_STORE  = 7'd21;
  localparam logic [6:0] OP_ADD    = 7'd30;
  localparam logic [6:0] OP_SUB    = 7'd31;
  localparam logic [6:0] OP_DIV    = 7'd32;
  localparam logic [6:0] OP_MUL    = 7'd33;
  localparam logic [6:0] OP_BR     = 7'd40;
  localparam logic [6:0] OP_BRNEG  = 7'd41;
  localparam logic [6:0] OP_BRZERO = 7'd42;
  localparam logic [6:0] OP_HALT   = 7'd43;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDBK,
    S_FETCH,
    S_DECODE,
    S_OPER,
    S_DIV,
    S_FIN
  } fsm_t;

endpackage

FILE: hdl/decimal_accumulator_machine.sv
// ----------------------------------------------------------------------------
// decimal_accumulator_machine
// Decimal accumulator machine: word memory, accumulator and instruction
// counter; each transaction loads, reads back, restarts or steps once.
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)                 | tuser
//  in_     | slave     | address[6:0], word[21:7]           | mode[1:0]
//  out_    | master    | status, accumulator_value,         | output_valid
//          |           | program_counter, instruction_word, |
//          |           | output_value, read_data            |
//
//  A divide runs the 14 steps of the one-bit-per-cycle divider, which makes it
//  the longest transaction. Every memory read goes through the single
//  registered RAM read port, so one transaction is in work at a time.
//  Reset clears the per-word valid bits at once; no clearing pass is needed.
//  A result waits in the output register; the next transaction is taken
//  meanwhile and stalls only at its own result if the first is still held.
// ----------------------------------------------------------------------------
module decimal_accumulator_machine #(
  parameter int MEM_WORDS = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // address[6:0], word[21:7]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // status[2:0], accumulator_value[17:3],
                                  // program_counter[24:18], instruction_word[39:25],
                                  // output_value[54:40], read_data[69:55]
  output logic        out_tuser   // output_valid
);
  import dam_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [PC_W-1:0] MEM_LIM = PC_W'(MEM_WORDS);

  fsm_t                     state_r, state_nxt;
  logic [PC_W-1:0]          addr_r, addr_nxt;
  logic signed [WORD_W-1:0] word_r, word_nxt;
  logic signed [WORD_W-1:0] acc_r, acc_nxt;
  logic [PC_W-1:0]          pc_r, pc_nxt;
  logic signed [WORD_W-1:0] ir_r, ir_nxt;
  status_t                  st_r, st_nxt;
  logic                     oflag_r, oflag_nxt;
  logic signed [WORD_W-1:0] ovalue_r, ovalue_nxt;
  logic signed [WORD_W-1:0] rdata_r, rdata_nxt;
  logic [6:0]               opq_r, opq_nxt;
  logic [MAG_W-1:0]         mag_r, mag_nxt;
  logic [MAG_W-1:0]         div_rem_r, div_rem_nxt;
  logic [MAG_W-1:0]         div_quo_r, div_quo_nxt;
  logic [MAG_W-1:0]         div_den_r, div_den_nxt;
  logic [DCNT_W-1:0]        div_cnt_r, div_cnt_nxt;
  logic                     div_neg_r, div_neg_nxt;
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [71:0]              out_data_r, out_data_nxt;
  logic                     out_user_r, out_user_nxt;
  logic [MEM_WORDS-1:0]     vld_r;
  logic                     rd_vld_r;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [WORD_W-1:0]        ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [WORD_W-1:0]        ram_rdata;
  logic signed [WORD_W-1:0] mem_q;

  // datapath temporaries
  mode_t                    in_mode;
  logic [PC_W-1:0]          in_addr;
  logic signed [WORD_W-1:0] in_word;
  logic signed [WORD_W-1:0] wneg;
  logic [26:0]              recip_p;
  logic [MAG_W-1:0]         hund;
  logic [MAG_W-1:0]         rem14;
  logic [6:0]               opr;
  logic                     opr_bad;
  logic signed [WORD_W-1:0] clamp_w;
  logic signed [15:0]       sum16;
  logic signed [15:0]       dif16;
  logic signed [29:0]       prod;
  logic signed [WORD_W-1:0] acc_abs;
  logic signed [WORD_W-1:0] d_abs;
  logic [MAG_W:0]           trial;
  logic [MAG_W:0]           trial_sub;
  logic [MAG_W-1:0]         quo_step;
  logic signed [WORD_W-1:0] quo_s;
  status_t                  st_fin;

  dam_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // never-written words read as zero
  assign mem_q = rd_vld_r ? $signed(ram_rdata) : '0;

  assign in_mode = mode_t'(in_tuser);
  assign in_addr = in_tdata[6:0];
  assign in_word = $signed(in_tdata[21:7]);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // opcode / operand split: quotient by reciprocal, remainder by shift-add
  always_comb begin
    wneg    = -mem_q;
    recip_p = 27'(mem_q[WORD_W-1] ? wneg[MAG_W-1:0] : mem_q[MAG_W-1:0]) * RECIP_100;
    hund    = MAG_W'({opq_r, 6'b0}) + MAG_W'({opq_r, 5'b0}) + MAG_W'({opq_r, 2'b0});
    rem14   = mag_r - hund;
    opr     = rem14[6:0];
    opr_bad = (ir_r[WORD_W-1] && (opr != '0)) || (opr >= MEM_LIM);
    if (word_r > WORD_MAX) begin
      clamp_w = WORD_MAX;
    end else if (word_r < WORD_MIN) begin
      clamp_w = WORD_MIN;
    end else begin
      clamp_w = word_r;
    end
    sum16     = {acc_r[WORD_W-1], acc_r} + {mem_q[WORD_W-1], mem_q};
    dif16     = {acc_r[WORD_W-1], acc_r} - {mem_q[WORD_W-1], mem_q};
    prod      = 30'(acc_r) * 30'(mem_q);
    acc_abs   = acc_r[WORD_W-1] ? -acc_r : acc_r;
    d_abs     = mem_q[WORD_W-1] ? -mem_q : mem_q;
    trial     = {div_rem_r, div_quo_r[MAG_W-1]};
    trial_sub = trial - {1'b0, div_den_r};
    quo_step  = {div_quo_r[MAG_W-2:0], (trial >= {1'b0, div_den_r})};
    quo_s     = div_neg_r ? -$signed({1'b0, quo_step}) : $signed({1'b0, quo_step});
    st_fin    = st_r;
    if ((pc_r >= MEM_LIM) && ((st_r == ST_RUN) || (st_r == ST_HALT))) begin
      st_fin = ST_PCRANGE;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    word_nxt       = word_r;
    acc_nxt        = acc_r;
    pc_nxt         = pc_r;
    ir_nxt         = ir_r;
    st_nxt         = st_r;
    oflag_nxt      = oflag_r;
    ovalue_nxt     = ovalue_r;
    rdata_nxt      = rdata_r;
    opq_nxt        = opq_r;
    mag_nxt        = mag_r;
    div_rem_nxt    = div_rem_r;
    div_quo_nxt    = div_quo_r;
    div_den_nxt    = div_den_r;
    div_cnt_nxt    = div_cnt_r;
    div_neg_nxt    = div_neg_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          addr_nxt   = in_addr;
          word_nxt   = in_word;
          oflag_nxt  = 1'b0;
          ovalue_nxt = '0;
          rdata_nxt  = '0;
          state_nxt  = S_FIN;
          unique case (in_mode)
            MODE_LOAD: begin
              if ((in_addr < MEM_LIM) && (in_word >= WORD_MIN) && (in_word <= WORD_MAX)) begin
                ram_we    = 1'b1;
                ram_waddr = in_addr[AW-1:0];
                ram_wdata = in_word;
              end
            end
            MODE_READ: begin
              ram_raddr = (in_addr < MEM_LIM) ? in_addr[AW-1:0] : '0;
              state_nxt = S_RDBK;
            end
            MODE_RESTART: begin
              acc_nxt = '0;
              pc_nxt  = '0;
              ir_nxt  = '0;
              st_nxt  = ST_RUN;
            end
            MODE_EXEC: begin
              if ((st_r == ST_RUN) && (pc_r < MEM_LIM)) begin
                ram_raddr = pc_r[AW-1:0];
                state_nxt = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end

      S_RDBK: begin
        rdata_nxt = (addr_r < MEM_LIM) ? mem_q : '0;
        state_nxt = S_FIN;
      end

      S_FETCH: begin
        ir_nxt    = mem_q;
        mag_nxt   = mem_q[WORD_W-1] ? wneg[MAG_W-1:0] : mem_q[MAG_W-1:0];
        opq_nxt   = recip_p[RECIP_SHIFT+6:RECIP_SHIFT];
        state_nxt = S_DECODE;
      end

      S_DECODE: begin
        state_nxt = S_FIN;
        if (opr_bad) begin
          st_nxt = ST_BADADDR;
        end else begin
          pc_nxt = pc_r + 7'd1;
          priority if (ir_r[WORD_W-1]) begin
            st_nxt = ST_BADOP;
          end else begin
            unique case (opq_r)
              OP_READ: begin
                ram_we    = 1'b1;
                ram_waddr = opr[AW-1:0];
                ram_wdata = clamp_w;
              end
              OP_STORE: begin
                ram_we    = 1'b1;
                ram_waddr = opr[AW-1:0];
                ram_wdata = acc_r;
              end
              OP_WRITE, OP_LOAD, OP_ADD, OP_SUB, OP_DIV, OP_MUL: begin
                ram_raddr = opr[AW-1:0];
                state_nxt = S_OPER;
              end
              OP_BR:     pc_nxt = opr;
              OP_BRNEG:  if (acc_r < 0) pc_nxt = opr;
              OP_BRZERO: if (acc_r == '0) pc_nxt = opr;
              OP_HALT:   st_nxt = ST_HALT;
              default:   st_nxt = ST_BADOP;
            endcase
          end
        end
      end

      S_OPER: begin
        state_nxt = S_FIN;
        unique case (opq_r)
          OP_WRITE: begin
            oflag_nxt  = 1'b1;
            ovalue_nxt = mem_q;
          end
          OP_LOAD: acc_nxt = mem_q;
          OP_ADD: begin
            if ((sum16 >= SUM_MIN) && (sum16 <= SUM_MAX)) acc_nxt = sum16[WORD_W-1:0];
            else st_nxt = ST_OVF;
          end
          OP_SUB: begin
            if ((dif16 >= SUM_MIN) && (dif16 <= SUM_MAX)) acc_nxt = dif16[WORD_W-1:0];
            else st_nxt = ST_OVF;
          end
          OP_MUL: begin
            if ((prod >= PROD_MIN) && (prod <= PROD_MAX)) acc_nxt = prod[WORD_W-1:0];
            else st_nxt = ST_OVF;
          end
          OP_DIV: begin
            if (mem_q == '0) begin
              st_nxt = ST_DIV0;
            end else begin
              div_rem_nxt = '0;
              div_quo_nxt = acc_abs[MAG_W-1:0];
              div_den_nxt = d_abs[MAG_W-1:0];
              div_cnt_nxt = '0;
              div_neg_nxt = acc_r[WORD_W-1] ^ mem_q[WORD_W-1];
              state_nxt   = S_DIV;
            end
          end
          default: ;
        endcase
      end

      S_DIV: begin
        // restoring division, one quotient bit per cycle
        div_rem_nxt = (trial >= {1'b0, div_den_r}) ? trial_sub[MAG_W-1:0] : trial[MAG_W-1:0];
        div_quo_nxt = quo_step;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DCNT_W'(DIV_BITS - 1)) begin
          acc_nxt   = quo_s;
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        st_nxt = st_fin;
        // hold here while the previous result is still unclaimed
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = {2'b0, rdata_r, ovalue_r, ir_r, pc_r, acc_r, st_fin};
          out_user_nxt   = oflag_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      pc_r         <= '0;
      ir_r         <= '0;
      st_r         <= ST_RUN;
      out_tvalid_r <= 1'b0;
      vld_r        <= '0;
    end else begin
      acc_r        <= acc_nxt;
      pc_r         <= pc_nxt;
      ir_r         <= ir_nxt;
      st_r         <= st_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    word_r     <= word_nxt;
    oflag_r    <= oflag_nxt;
    ovalue_r   <= ovalue_nxt;
    rdata_r    <= rdata_nxt;
    opq_r      <= opq_nxt;
    mag_r      <= mag_nxt;
    div_rem_r  <= div_rem_nxt;
    div_quo_r  <= div_quo_nxt;
    div_den_r  <= div_den_nxt;
    div_cnt_r  <= div_cnt_nxt;
    div_neg_r  <= div_neg_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    rd_vld_r   <= vld_r[ram_raddr];
  end

endmodule

FILE: hdl/dam_ram.sv
// ----------------------------------------------------------------------------
// dam_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dam_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/dam_checker.sv
// ----------------------------------------------------------------------------
// dam_checker
// Port-level checks for the decimal accumulator machine, bound to the top.
// ----------------------------------------------------------------------------
module dam_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tuser
);
  import dam_pkg::*;

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // one transaction in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while busy");

  a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] <= ST_PCRANGE) && (out_tdata[24:18] <= 7'd100))
    else $error("status or counter out of range");

  a_quiet_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata[54:40] == '0))
    else $error("output value without write");

endmodule

bind decimal_accumulator_machine dam_checker u_dam_checker (.*);

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the decimal accumulator machine. A directed list
// covers the corner cases: ignored loads, out-of-range read back, clamped
// read, overflow, divide by zero, bad operand, bad opcode, halt and running
// off the end. After it come random program runs mixed with noise items.
// Every result is compared field by field with an in-bench model of the
// machine. Both sides of the stream idle in random bursts.
// ----------------------------------------------------------------------------
module tb;
  import dam_pkg::*;

  localparam int MEM_WORDS = 100;
  localparam int ITEMS     = 1050;
  localparam int LIMIT     = 4000;
  localparam int PLAN_LEN  = 32;

  typedef struct {
    status_t            status;
    logic signed [14:0] acc;
    logic [6:0]         pc;
    logic signed [14:0] instr;
    logic               ov;
    logic signed [14:0] oval;
    logic signed [14:0] rdata;
  } machine_view_t;

  // one stimulus row; status and read data are typed in where known
  typedef struct packed {
    mode_t              m;
    logic [6:0]         a;
    logic signed [14:0] w;
    logic               known;
    status_t            st;
    logic signed [14:0] rd;
  } vector_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;  // address[6:0], word[21:7]
  logic [1:0]  in_tuser   = '0;  // mode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;        // status, accumulator_value, program_counter,
                                 // instruction_word, output_value, read_data
  logic        out_tuser;        // output_valid

  decimal_accumulator_machine #(.MEM_WORDS(MEM_WORDS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // machine image kept by the bench
  int      mem_image [MEM_WORDS];
  int      acc_now;
  int      pc_now;
  int      last_word;
  status_t run_state = ST_RUN;

  machine_view_t awaited_views [$];
  int errors            = 0;
  int items_sent        = 0;
  int results_seen      = 0;
  int gap_pct           = 0;
  int stall_pct         = 0;
  int stall_left        = 0;
  int hold_left         = 0;
  int long_holds_asked  = 0;
  int long_holds_served = 0;
  int quiet_cycles      = 0;
  bit calm              = 1'b0;

  vector_t plan [PLAN_LEN] = '{
    '{MODE_READ,    7'd0,   15'sd0,      1'b1, ST_RUN,     15'sd0},
    '{MODE_READ,    7'd127, 15'sd0,      1'b1, ST_RUN,     15'sd0},
    '{MODE_LOAD,    7'd99,  15'sd9999,   1'b1, ST_RUN,     15'sd0},
    '{MODE_LOAD,    7'd100, 15'sd1,      1'b1, ST_RUN,     15'sd0},
    '{MODE_LOAD,    7'd98,  -15'sd10000, 1'b1, ST_RUN,     15'sd0},
    '{MODE_READ,    7'd99,  15'sd0,      1'b1, ST_RUN,     15'sd9999},
    '{MODE_READ,    7'd98,  15'sd0,      1'b1, ST_RUN,     15'sd0},
    '{MODE_LOAD,    7'd0,   15'sd1097,   1'b1, ST_RUN,     15'sd0},
    '{MODE_LOAD,    7'd1,   15'sd2097,   1'b1, ST_RUN,     15'sd0},
    '{MODE_LOAD,    7'd2,   15'sd3099,   1'b1, ST_RUN,     15'sd0},
    '{MODE_EXEC,    7'd0,   15'sd16383,  1'b0, ST_RUN,     15'sd0},
    '{MODE_EXEC,    7'd0,   15'sd0,      1'b0, ST_RUN,     15'sd0},
    '{MODE_EXEC,    7'd0,   15'sd0,      1'b1, ST_OVF,     15'sd0},
    '{MODE_READ,    7'd97,  15'sd0,      1'b1, ST_OVF,     15'sd9999},
    '{MODE_RESTART, 7'd0,   15'sd0,      1'b1, ST_RUN,     15'sd0},
    '{MODE_LOAD,    7'd0,   15'sd3296,   1'b1, ST_RUN,     15'sd0},
    '{MODE_EXEC,    7'd0,   15'sd0,      1'b1, ST_DIV0,    15'sd0},
    '{MODE_RESTART, 7'd0,   15'sd0,      1'b1, ST_RUN,     15'sd0},
    '{MODE_LOAD,    7'd0,   -15'sd101,   1'b1, ST_RUN,     15'sd0},
    '{MODE_EXEC,    7'd0,   15'sd0,      1'b1, ST_BADADDR, 15'sd0},
    '{MODE_RESTART, 7'd0,   15'sd0,      1'b1, ST_RUN,     15'sd0},
    '{MODE_LOAD,    7'd0,   15'sd4400,   1'b1, ST_RUN,     15'sd0},
    '{MODE_EXEC,    7'd0,   15'sd0,      1'b1, ST_BADOP,   15'sd0},
    '{MODE_RESTART, 7'd0,   15'sd0,      1'b1, ST_RUN,     15'sd0},
    '{MODE_LOAD,    7'd0,   15'sd4099,   1'b1, ST_RUN,     15'sd0},
    '{MODE_LOAD,    7'd99,  15'sd4300,   1'b1, ST_RUN,     15'sd0},
    '{MODE_EXEC,    7'd0,   15'sd0,      1'b0, ST_RUN,     15'sd0},
    '{MODE_EXEC,    7'd0,   15'sd0,      1'b1, ST_PCRANGE, 15'sd0},
    '{MODE_RESTART, 7'd0,   15'sd0,      1'b1, ST_RUN,     15'sd0},
    '{MODE_LOAD,    7'd0,   15'sd4300,   1'b1, ST_RUN,     15'sd0},
    '{MODE_EXEC,    7'd0,   15'sd0,      1'b1, ST_HALT,    15'sd0},
    '{MODE_EXEC,    7'd127, 15'h4000,    1'b1, ST_HALT,    15'sd0}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int s15(logic [14:0] v);
    return int'($signed(v));
  endfunction

  // advance the machine image by one transaction and return what it reports
  function automatic machine_view_t step_machine(mode_t m, logic [6:0] a,
                                                 logic signed [14:0] w);
    machine_view_t v;
    int wv, opc, opd, r;
    wv      = w;
    v.ov    = 1'b0;
    v.oval  = '0;
    v.rdata = '0;
    case (m)
      MODE_LOAD: begin
        if (a < MEM_WORDS && wv >= WORD_MIN && wv <= WORD_MAX) mem_image[a] = wv;
      end
      MODE_READ: begin
        if (a < MEM_WORDS) v.rdata = 15'(mem_image[a]);
      end
      MODE_RESTART: begin
        acc_now   = 0;
        pc_now    = 0;
        last_word = 0;
        run_state = ST_RUN;
      end
      default: begin
        if (run_state == ST_RUN && pc_now >= MEM_WORDS) begin
          run_state = ST_PCRANGE;
        end else if (run_state == ST_RUN) begin
          last_word = mem_image[pc_now];
          opc = last_word / 100;
          opd = last_word % 100;
          if (opd < 0 || opd >= MEM_WORDS) begin
            run_state = ST_BADADDR;
          end else begin
            pc_now++;
            case (opc)
              OP_READ: begin
                // clamp the supplied value into word range
                if (wv > WORD_MAX) wv = WORD_MAX;
                if (wv < WORD_MIN) wv = WORD_MIN;
                mem_image[opd] = wv;
              end
              OP_WRITE: begin
                v.ov   = 1'b1;
                v.oval = 15'(mem_image[opd]);
              end
              OP_LOAD:  acc_now = mem_image[opd];
              OP_STORE: mem_image[opd] = acc_now;
              OP_ADD, OP_SUB, OP_MUL: begin
                if (opc == OP_ADD)      r = acc_now + mem_image[opd];
                else if (opc == OP_SUB) r = acc_now - mem_image[opd];
                else                    r = acc_now * mem_image[opd];
                if (r >= WORD_MIN && r <= WORD_MAX) acc_now = r;
                else run_state = ST_OVF;
              end
              OP_DIV: begin
                if (mem_image[opd] == 0) run_state = ST_DIV0;
                else acc_now = acc_now / mem_image[opd];
              end
              OP_BR:     pc_now = opd;
              OP_BRNEG:  if (acc_now < 0) pc_now = opd;
              OP_BRZERO: if (acc_now == 0) pc_now = opd;
              OP_HALT:   run_state = ST_HALT;
              default:   run_state = ST_BADOP;
            endcase
            if (pc_now >= MEM_WORDS && (run_state == ST_RUN || run_state == ST_HALT))
              run_state = ST_PCRANGE;
          end
        end
      end
    endcase
    v.status = run_state;
    v.acc    = 15'(acc_now);
    v.pc     = 7'(pc_now);
    v.instr  = 15'(last_word);
    return v;
  endfunction

  task automatic log_mismatch(string what);
    errors++;
    $display("mismatch at result %0d: %s", results_seen, what);
  endtask

  task automatic compare_field(string name, int got, int want);
    if (got != want) log_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  task automatic send_item(vector_t row);
    machine_view_t view;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= row.m;
    in_tdata  <= {2'b00, row.w, row.a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    view = step_machine(row.m, row.a, row.w);
    if (row.known) begin
      view.status = row.st;
      view.rdata  = row.rd;
    end
    awaited_views.push_back(view);
    items_sent++;
    if (items_sent % 64 == 0) gap_pct = $urandom_range(0, 1) ? 30 : 0;
  endtask

  task automatic issue(mode_t m, int a, int w);
    vector_t row;
    row.m     = m;
    row.a     = 7'(a);
    row.w     = 15'(w);
    row.known = 1'b0;
    row.st    = ST_RUN;
    row.rd    = '0;
    send_item(row);
  endtask

  task automatic issue_noise();
    issue(mode_t'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom_range(0, 32767));
  endtask

  // restart, fill a data pool, load a short program and step through it
  task automatic run_program();
    int pool [4];
    int base, span, opc, opd, wd, steps, top;
    issue(MODE_RESTART, $urandom_range(0, 127), $urandom_range(0, 32767));
    foreach (pool[i]) begin
      pool[i] = $urandom_range(0, MEM_WORDS - 1);
      case ($urandom_range(0, 3))
        0:       wd = 0;
        1:       wd = int'($urandom_range(0, 40)) - 20;
        2:       wd = int'($urandom_range(0, 19998)) - 9999;
        default: wd = $urandom_range(0, 1) ? 9999 : -9999;
      endcase
      issue(MODE_LOAD, pool[i], wd);
    end
    base = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MEM_WORDS - 1) : 0;
    span = $urandom_range(2, 8);
    top  = (base + span < MEM_WORDS) ? base + span : MEM_WORDS - 1;
    // jump to a program that does not start at zero
    if (base != 0) issue(MODE_LOAD, 0, OP_BR * 100 + base);
    for (int i = 0; i < span && base + i < MEM_WORDS; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        wd = int'($urandom_range(0, 19998)) - 9999;
      end else begin
        case ($urandom_range(0, 11))
          0:       opc = OP_READ;
          1:       opc = OP_WRITE;
          2:       opc = OP_LOAD;
          3:       opc = OP_STORE;
          4:       opc = OP_ADD;
          5:       opc = OP_SUB;
          6:       opc = OP_DIV;
          7:       opc = OP_MUL;
          8:       opc = OP_BR;
          9:       opc = OP_BRNEG;
          10:      opc = OP_BRZERO;
          default: opc = OP_HALT;
        endcase
        if (opc == OP_BR || opc == OP_BRNEG || opc == OP_BRZERO)
          opd = $urandom_range(base, top);
        else if ($urandom_range(0, 4) == 0)
          opd = $urandom_range(0, MEM_WORDS - 1);
        else
          opd = pool[$urandom_range(0, 3)];
        wd = opc * 100 + opd;
      end
      issue(MODE_LOAD, base + i, wd);
      if ($urandom_range(0, 9) == 0) issue_noise();
    end
    steps = span + $urandom_range(0, 3) + (base != 0);
    repeat (steps) begin
      if ($urandom_range(0, 3) == 0) wd = $urandom_range(0, 32767);
      else wd = int'($urandom_range(0, 19998)) - 9999;
      issue(MODE_EXEC, $urandom_range(0, 127), wd);
      if ($urandom_range(0, 11) == 0) issue_noise();
    end
  endtask

  // result side: check, then decide readiness for the next cycle
  always @(posedge clk) begin
    machine_view_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_views.size() == 0) begin
        log_mismatch("transaction with no expected result");
      end else begin
        want = awaited_views.pop_front();
        compare_field("status", out_tdata[2:0], want.status);
        compare_field("accumulator", s15(out_tdata[17:3]), s15(want.acc));
        compare_field("pc", out_tdata[24:18], want.pc);
        compare_field("instruction", s15(out_tdata[39:25]), s15(want.instr));
        compare_field("output_valid", out_tuser, want.ov);
        compare_field("output_value", s15(out_tdata[54:40]), s15(want.oval));
        compare_field("read_data", s15(out_tdata[69:55]), s15(want.rdata));
      end
      results_seen++;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (long_holds_served < long_holds_asked) begin
      // long hold-off: let the block fill up and stall its input
      long_holds_served++;
      hold_left = 150;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
    if ($urandom_range(0, 199) == 0) stall_pct = (stall_pct != 0) ? 0 : 35;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= LIMIT) begin
      $display("timeout: no transaction for %0d cycles", LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    bit drained_once;
    drained_once = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (plan[i]) send_item(plan[i]);
    while (items_sent < ITEMS) begin
      if (items_sent >= ITEMS - 120) calm = 1'b1;
      if (items_sent > 300 && long_holds_asked == 0) long_holds_asked = 1;
      // pause the input until every result is back
      if ((items_sent > 650 && !drained_once) || (!calm && $urandom_range(0, 11) == 0)) begin
        drained_once = 1'b1;
        if (awaited_views.size() != 0) begin
          in_tvalid <= 1'b0;
          while (awaited_views.size() != 0) @(posedge clk);
        end
      end
      run_program();
    end
    in_tvalid <= 1'b0;
    while (awaited_views.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
